// ===== rtl/wwas_pkg.sv =====
// Package for the wrapped-window axis mapper: widths, register indexes,
// serial step counts and the controller state type. No dependencies.
package wwas_pkg;

  localparam int SAMPLE_BITS = 13;

  localparam int HALF_W    = 11;
  localparam int SCALE_W   = 12;
  localparam int HEIGHT_W  = 14;
  localparam int POS_W     = 16;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;

  // bounds reach sample max + half_width, or just below full_scale after a wrap
  localparam int BOUND_W = ((SAMPLE_BITS > SCALE_W) ? SAMPLE_BITS : SCALE_W) + 2;
  localparam int OFF_W   = BOUND_W + 1;
  localparam int DIFF_W  = OFF_W + 1;
  localparam int PROD_W  = DIFF_W + HEIGHT_W;
  localparam int DEN_W   = 12;
  localparam int D_W     = 6;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam int PERCENT   = 100;
  localparam int PCT_W     = 7;
  // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
  localparam int RECIP     = 5243;
  localparam int RECIP_W   = 13;
  localparam int RECIP_SH  = 19;

  localparam int POS_MAX = 32767;
  localparam int POS_MIN_MAG = 32768;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAPTURE,
    ST_CLAMP,
    ST_OFFSET,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/wwas_sample_if.sv =====
// Input channel of the axis mapper: valid/ready plus one signed sample.
// Depends on wwas_pkg.
interface wwas_sample_if;
  import wwas_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/wwas_result_if.sv =====
// Result channel of the axis mapper: valid/ready, position and accepted flag.
// Depends on wwas_pkg.
interface wwas_result_if;
  import wwas_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic                    accepted;

  modport source (output valid, output position, output accepted, input ready);
  modport sink   (input valid, input position, input accepted, output ready);
endinterface

// ===== rtl/wrapped_window_axis_to_screen.sv =====
// Wrapped-window axis mapper: top level with controller, serial multiplier
// and restoring divider. Depends on wwas_pkg, wwas_sample_if, wwas_result_if.
//
//   channel   dir  payload                  handshake
//   samples   in   sample (13b signed)      valid/ready
//   results   out  position (16b), accepted valid/ready
//   cfg       in   cfg_index, cfg_data      cfg_we, no back-pressure
//
// After a sample is accepted, the controller steps through capture, clamp
// and offset, then the shift-add multiplier (one cycle per height bit) and
// the restoring divider (one per quotient bit), and loads the result once
// the output register is free. A negative sample skips straight to the load.
// The block goes back to idle after the load, before it takes a new sample.
// A new sample is taken while the output register still holds a result.
// Reset is synchronous; no clearing pass, the block is ready right after it.
module wrapped_window_axis_to_screen (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wwas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wwas_pkg::CFG_W-1:0]         cfg_data,
  wwas_sample_if.sink                        samples,
  wwas_result_if.source                      results
);
  import wwas_pkg::*;

  logic [HALF_W-1:0]   half_width;
  logic [SCALE_W-1:0]  full_scale;
  logic [HEIGHT_W-1:0] screen_height;

  state_t state, state_next;

  logic                      need_capture;
  logic                      wraps;
  logic signed [BOUND_W-1:0] low_bound;
  logic signed [BOUND_W-1:0] high_bound;
  logic signed [BOUND_W-1:0] smp;
  logic signed [BOUND_W-1:0] y;
  logic                      rejected;
  logic [D_W-1:0]            d;
  logic [DEN_W-1:0]          den;
  logic                      diff_neg;
  logic [DIFF_W-1:0]         mcand;
  logic [PROD_W:0]           prod;
  logic [PROD_W-1:0]         quot;
  logic [DEN_W-1:0]          rem;
  logic [CNT_W-1:0]          cnt;

  logic                      out_valid;
  logic signed [POS_W-1:0]   position;
  logic                      accepted;

  logic take_in;
  logic load_out;
  logic mul_last;
  logic div_last;

  // capture
  logic signed [BOUND_W-1:0] hw_s, fs_s, lo_raw, hi_raw, lo_cap, hi_cap;
  logic                      lo_wrap, hi_wrap;
  // clamp and scale
  logic signed [BOUND_W-1:0]           y_c;
  logic [HALF_W+1+RECIP_W-1:0]         recip_prod;
  logic [D_W-1:0]                      d_c;
  // offset
  logic signed [OFF_W-1:0]   off_raw, off_c;
  logic [DEN_W-1:0]          den_c;
  logic signed [DIFF_W-1:0]  diff_c;
  // serial steps
  logic [DIFF_W:0]           mul_sum;
  logic [DEN_W+1:0]          trial;
  logic                      borrow;
  logic signed [POS_W-1:0]   pos_c;

  always_comb begin
    hw_s    = $signed(BOUND_W'(half_width));
    fs_s    = $signed(BOUND_W'(full_scale));
    lo_raw  = smp - hw_s;
    hi_raw  = smp + hw_s;
    lo_wrap = lo_raw < 0;
    hi_wrap = hi_raw > fs_s;
    lo_cap  = lo_wrap ? lo_raw + fs_s : lo_raw;
    hi_cap  = hi_wrap ? hi_raw - fs_s : hi_raw;
  end

  always_comb begin
    y_c = smp;
    if (!wraps) begin
      if (smp > high_bound) begin
        y_c = high_bound;
      end else if (smp < low_bound) begin
        y_c = low_bound;
      end
    end else if (smp > high_bound && smp < low_bound) begin
      y_c = high_bound;
    end
    // d = floor(2*half_width / 100), never below 1
    recip_prod = (HALF_W + 1 + RECIP_W)'({half_width, 1'b0})
               * (HALF_W + 1 + RECIP_W)'(RECIP);
    d_c = recip_prod[RECIP_SH +: D_W];
    if (d_c == '0) begin
      d_c = D_W'(1);
    end
  end

  always_comb begin
    off_raw = OFF_W'(y) - OFF_W'(low_bound);
    off_c   = (off_raw < 0 && wraps) ? off_raw + $signed(OFF_W'(full_scale)) : off_raw;
    den_c   = DEN_W'(d) * DEN_W'(PERCENT);
    diff_c  = $signed(DIFF_W'(den_c)) - DIFF_W'(off_c);
  end

  always_comb begin
    mul_sum = prod[PROD_W:HEIGHT_W] + (prod[0] ? {1'b0, mcand} : '0);
    trial   = {1'b0, rem, quot[PROD_W-1]} - {2'b00, den};
    borrow  = trial[DEN_W+1];
  end

  always_comb begin
    pos_c = '0;
    if (!rejected) begin
      if (diff_neg) begin
        if (quot > PROD_W'(POS_MIN_MAG)) begin
          pos_c = $signed(POS_W'(POS_MIN_MAG));
        end else begin
          pos_c = -$signed(quot[POS_W-1:0]);
        end
      end else if (quot > PROD_W'(POS_MAX)) begin
        pos_c = $signed(POS_W'(POS_MAX));
      end else begin
        pos_c = $signed(quot[POS_W-1:0]);
      end
    end
  end

  // controller outputs
  always_comb begin
    samples.ready = (state == ST_IDLE);
    take_in       = samples.valid && (state == ST_IDLE);
    load_out      = (state == ST_FIN) && (!out_valid || results.ready);
    mul_last      = (cnt == CNT_W'(HEIGHT_W - 1));
    div_last      = (cnt == CNT_W'(PROD_W - 1));
  end

  // controller next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_in) begin
          state_next = samples.sample[SAMPLE_BITS-1] ? ST_FIN : ST_CAPTURE;
        end
      end
      ST_CAPTURE: state_next = ST_CLAMP;
      ST_CLAMP:   state_next = ST_OFFSET;
      ST_OFFSET:  state_next = ST_MUL;
      ST_MUL: begin
        if (mul_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      half_width    <= HALF_W'(200);
      full_scale    <= SCALE_W'(1000);
      screen_height <= HEIGHT_W'(1080);
      need_capture  <= 1'b1;
      wraps         <= 1'b0;
      low_bound     <= '0;
      high_bound    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_WIDTH:    half_width    <= cfg_data[HALF_W-1:0];
          REG_FULL_SCALE:    full_scale    <= cfg_data[SCALE_W-1:0];
          REG_SCREEN_HEIGHT: screen_height <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_CAPTURE && need_capture) begin
        need_capture <= 1'b0;
        low_bound    <= lo_cap;
        high_bound   <= hi_cap;
        if (lo_wrap || hi_wrap) begin
          wraps <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take_in) begin
          smp      <= BOUND_W'(samples.sample);
          rejected <= samples.sample[SAMPLE_BITS-1];
        end
      end
      ST_CLAMP: begin
        y <= y_c;
        d <= d_c;
      end
      ST_OFFSET: begin
        den      <= den_c;
        diff_neg <= diff_c < 0;
        mcand    <= (diff_c < 0) ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
        prod     <= (PROD_W + 1)'(screen_height);
        cnt      <= '0;
      end
      ST_MUL: begin
        // shift-add, one bit of screen_height per cycle
        prod <= {1'b0, mul_sum, prod[HEIGHT_W-1:1]};
        if (mul_last) begin
          cnt <= '0;
          rem <= '0;
          // product after the last step
          quot <= {mul_sum, prod[HEIGHT_W-1:1]};
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        cnt <= cnt + CNT_W'(1);
        if (!borrow) begin
          rem  <= trial[DEN_W-1:0];
          quot <= {quot[PROD_W-2:0], 1'b1};
        end else begin
          rem  <= {rem[DEN_W-2:0], quot[PROD_W-1]};
          quot <= {quot[PROD_W-2:0], 1'b0};
        end
      end
      ST_FIN: begin
        if (rejected) begin
          quot <= '0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      position <= pos_c;
      accepted <= !rejected;
    end
  end

  assign results.valid    = out_valid;
  assign results.position = position;
  assign results.accepted = accepted;

endmodule
